// ----- src/scalar_kalman_filter_top_assert.svh -----
// Assertion macros shared by the scalar Kalman filter RTL.
// Depends on signals clk and rst_n being in scope where the macros are used.
// Include guard keeps the definitions single.
`ifndef SCALAR_KALMAN_FILTER_TOP_ASSERT_SVH
`define SCALAR_KALMAN_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SKF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("skf assertion failed");

// Next-cycle implication, disabled during reset.
`define SKF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("skf assertion failed");

`endif

// ----- src/skf_pkg.sv -----
// Package for the scalar Kalman filter: widths, constants, register indexes,
// controller states and the command/status structs. No dependencies.
package skf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 24;
    localparam int GAIN_W    = FRAC_BITS + 1;
    localparam int P1_W      = DATA_W + 1;
    localparam int DEN_W     = DATA_W + 2;
    localparam int REM_W     = DATA_W + 2;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int PROD_W    = GAIN_W + 1 + DIFF_W;
    localparam int PN_W      = GAIN_W + DATA_W;
    localparam int CNT_W     = $clog2(GAIN_W);
    localparam int CFG_IDX_W = 2;
    localparam int ONE_INT   = 1 << FRAC_BITS;

    localparam logic [GAIN_W-1:0] ONE_GAIN  = GAIN_W'(ONE_INT);
    localparam logic [DATA_W-1:0] ERR_EST   = DATA_W'(-ONE_INT);
    localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(GAIN_W - 1);

    // Reset values of the noise terms and the filter state
    localparam logic [DATA_W-1:0] RST_Q = DATA_W'(6554);
    localparam logic [DATA_W-1:0] RST_R = DATA_W'(6554);
    localparam logic [DATA_W-1:0] RST_X = DATA_W'(327680);
    localparam logic [DATA_W-1:0] RST_P = DATA_W'(6554);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROCESS_NOISE      = 2'd0,
        REG_MEASUREMENT_NOISE  = 2'd1,
        REG_INITIAL_ESTIMATE   = 2'd2,
        REG_INITIAL_COVARIANCE = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRED,
        S_DIV,
        S_MUL,
        S_UPD,
        S_WRITE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic pred;
        logic div_step;
        logic mul;
        logic upd;
        logic write_out;
    } cmd_t;

    typedef struct packed {
        logic err;
        logic out_busy;
    } status_t;

endpackage

// ----- src/skf_ctrl.sv -----
// Controller state machine for the scalar Kalman filter.
// Depends on skf_pkg; drives the datapath through cmd_t and reads status_t.
module skf_ctrl
    import skf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t st,
    output cmd_t    cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_PRED;
            end
            S_PRED:  state_next = S_DIV;
            S_DIV:
            begin
                if (st.err)
                    state_next = S_WRITE;
                else if (cnt_reg == DIV_LAST)
                    state_next = S_MUL;
            end
            S_MUL:   state_next = S_UPD;
            S_UPD:   state_next = S_WRITE;
            S_WRITE:
            begin
                if (!st.out_busy)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Divider step counter
    always_comb
    begin
        cnt_next = '0;
        if (state_reg == S_DIV && !st.err)
            cnt_next = cnt_reg + CNT_W'(1);
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.load_in = in_valid;
            end
            S_PRED:  cmd.pred      = 1'b1;
            S_DIV:   cmd.div_step  = !st.err;
            S_MUL:   cmd.mul       = 1'b1;
            S_UPD:   cmd.upd       = 1'b1;
            S_WRITE: cmd.write_out = !st.out_busy;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- src/skf_datapath.sv -----
// Datapath of the scalar Kalman filter: config and state registers, the
// restoring divider for the gain, two multipliers and the output register.
// Depends on skf_pkg and scalar_kalman_filter_top_assert.svh.
`include "scalar_kalman_filter_top_assert.svh"

module skf_datapath
    import skf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output status_t                  st,
    input  logic signed [DATA_W-1:0] measurement,
    input  logic                     cfg_valid,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] estimate,
    output logic [GAIN_W-1:0]        gain,
    output logic                     error
);

    logic [DATA_W-1:0]        q_reg, q_next;
    logic [DATA_W-1:0]        r_reg, r_next;
    logic signed [DATA_W-1:0] x_reg, x_next;
    logic [DATA_W-1:0]        p_reg, p_next;
    logic signed [DATA_W-1:0] m_reg;
    logic [P1_W-1:0]          p1_reg;
    logic [P1_W-1:0]          den_reg;
    logic                     err_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [GAIN_W-1:0]        quo_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [PN_W-1:0]          pn_reg;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] est_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic                     error_reg;

    logic [P1_W-1:0]          p1_sum;
    logic [DEN_W-1:0]         den_sum;
    logic                     div_ge;
    logic [REM_W-1:0]         div_diff;
    logic signed [DIFF_W-1:0] innov;
    logic signed [PROD_W-1:0] prod_mul;
    logic [GAIN_W-1:0]        one_minus_k;
    logic [PN_W-1:0]          pn_mul;
    logic signed [PROD_W-1:0] x_sum;

    // Prediction: p1 = p + q, divisor p1 + r
    assign p1_sum  = {1'b0, p_reg} + {1'b0, q_reg};
    assign den_sum = {1'b0, p1_sum} + {2'b00, r_reg};

    // One restoring divider step per cycle
    assign div_ge   = rem_reg >= {1'b0, den_reg};
    assign div_diff = div_ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    // Products for the estimate and covariance updates
    assign innov       = {m_reg[DATA_W-1], m_reg} - {x_reg[DATA_W-1], x_reg};
    assign prod_mul    = $signed({1'b0, quo_reg}) * innov;
    assign one_minus_k = ONE_GAIN - quo_reg;
    assign pn_mul      = one_minus_k * p1_reg[DATA_W-1:0];

    // New estimate; shift right is a floor
    assign x_sum = PROD_W'(x_reg) + (prod_reg >>> FRAC_BITS);

    // Filter state and configuration
    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        x_next = x_reg;
        p_next = p_reg;
        if (cmd.upd)
        begin
            x_next = x_sum[DATA_W-1:0];
            p_next = pn_reg[FRAC_BITS +: DATA_W];
        end
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_PROCESS_NOISE:      q_next = cfg_data;
                REG_MEASUREMENT_NOISE:  r_next = cfg_data;
                REG_INITIAL_ESTIMATE:   x_next = cfg_data;
                REG_INITIAL_COVARIANCE: p_next = cfg_data;
                default:                q_next = q_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= RST_Q;
            r_reg <= RST_R;
            x_reg <= RST_X;
            p_reg <= RST_P;
        end
        else
        begin
            q_reg <= q_next;
            r_reg <= r_next;
            x_reg <= x_next;
            p_reg <= p_next;
        end
    end

    // Working registers of one request
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            m_reg <= measurement;
        if (cmd.pred)
        begin
            p1_reg  <= p1_sum;
            den_reg <= den_sum[P1_W-1:0];
            rem_reg <= {1'b0, p1_sum};
            quo_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= {div_diff[REM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[GAIN_W-2:0], div_ge};
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_mul;
            pn_reg   <= pn_mul;
        end
    end

    // Error flag: p + q overflowed or the divisor is zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            err_reg <= 1'b0;
        else if (cmd.pred)
            err_reg <= p1_sum[P1_W-1] || (den_sum == '0);
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.write_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_out)
        begin
            est_reg   <= err_reg ? ERR_EST : x_reg;
            gain_reg  <= err_reg ? '0 : quo_reg;
            error_reg <= err_reg;
        end
    end

    assign st.err      = err_reg;
    assign st.out_busy = out_valid_reg && out_stall;
    assign out_valid   = out_valid_reg;
    assign estimate    = est_reg;
    assign gain        = gain_reg;
    assign error       = error_reg;

    `SKF_ASSERT_IMP(a_err_result, out_valid_reg && error_reg,
        gain_reg == '0 && est_reg == ERR_EST)
    `SKF_ASSERT_IMP(a_gain_range, out_valid_reg && !error_reg, gain_reg <= ONE_GAIN)
    `SKF_ASSERT_NXT(a_cov_bound, cmd.upd && !cfg_valid,
        P1_W'(p_reg) <= $past(p1_reg))

endmodule

// ----- src/scalar_kalman_filter_top.sv -----
// Scalar Kalman filter, top level: controller and datapath.
// Depends on skf_pkg, skf_ctrl and skf_datapath.
//
// Usage:
//   One measurement request (signed Q8.16) enters on in_valid/in_stall and
//   produces one result request (estimate, gain, error) on out_valid/out_stall.
//   A request moves at a clock edge with valid high and stall low.
//   Configuration writes use cfg_valid/cfg_ready (ready is always high):
//   index 0 process noise, 1 measurement noise, 2 initial estimate (also loads
//   the estimate), 3 initial covariance (also loads the covariance). Write
//   only while the block is idle.
//   After input acceptance come a prediction state, the 17-step restoring
//   divider that forms the gain, a multiply, an update and a write state that
//   loads the output register; on an error the divider stops and write follows.
//   A new measurement is accepted only in idle, after the write state.
//   The output register holds the result while out_stall is high; one more
//   request is accepted and computed meanwhile, then waits in the write stage
//   with the input stalled until the held result has left.
//   Reset (rst_n low, asynchronous) restores noise terms to 6554, estimate to
//   5.0, covariance to 6554 and drops out_valid.
module scalar_kalman_filter_top
    import skf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [DATA_W-1:0] measurement,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] estimate,
    output logic [GAIN_W-1:0]        gain,
    output logic                     error,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data
);

    cmd_t    cmd;
    status_t st;

    assign cfg_ready = 1'b1;

    skf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    skf_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .measurement (measurement),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .estimate    (estimate),
        .gain        (gain),
        .error       (error)
    );

endmodule
